### hw/rtl/fbtc_pkg.sv
//------------------------------------------------------------------------------
// fbtc_pkg: shared types and codes for the free block table
// Entry layout, arithmetic unit results, sequencer states and field codes.
//------------------------------------------------------------------------------
`default_nettype none

package fbtc_pkg;

   // One table entry: start address and saturated size.
   typedef struct packed {
      logic [15:0] start;
      logic [23:0] length;
   } entry_type;

   // Flags and result from the shared arithmetic unit.
   typedef struct packed {
      logic        eq;
      logic        gt;
      logic [23:0] sat;
   } alu_res_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_INS_PUT,
      S_ACK,
      S_EMPTY,
      S_DMP_RD0,
      S_DMP_LOAD,
      S_DMP_RD,
      S_DMP_ADJ,
      S_DMP_SUM,
      S_DMP_EMIT,
      S_DMP_FIN
   } state_type;

   // Input mode codes.
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DUMP   = 1'b1;

   // Result kind codes.
   localparam logic KIND_ACK   = 1'b0;
   localparam logic KIND_ENTRY = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Largest size that an entry can hold.
   localparam logic [23:0] SIZE_MAX = 24'hFFFFFF;

endpackage

`default_nettype wire

### hw/rtl/fbtc_alu.sv
//------------------------------------------------------------------------------
// fbtc_alu: shared add and compare unit
// Forms a + b exactly, compares it with c and gives a saturated 24-bit sum.
//------------------------------------------------------------------------------
`default_nettype none

module fbtc_alu
   import fbtc_pkg::*;
(
   input  wire logic [23:0] a,
   input  wire logic [23:0] b,
   input  wire logic [15:0] c,
   output alu_res_type      res
);

   logic [24:0] sum;
   logic [24:0] c_ext;

   // One wide add, then the compares against the third operand.
   assign sum   = {1'b0, a} + {1'b0, b};
   assign c_ext = {9'd0, c};

   assign res.eq  = (sum == c_ext);
   assign res.gt  = (c_ext > sum);
   assign res.sat = sum[24] ? SIZE_MAX : sum[23:0];

endmodule

`default_nettype wire

### hw/rtl/free_block_table_coalesce.sv
//------------------------------------------------------------------------------
// free_block_table_coalesce: address-ordered free block table with merging
// Stores free blocks sorted by address; merges neighbours on a dump.
//------------------------------------------------------------------------------
// Usage:
// An item on the req_ channel with req_mode insert places one block in the
// table and answers with one acknowledgement (rsp_kind 0). A full table
// drops the block and answers with status full. A dump item merges touching
// neighbours and lists every remaining entry on the rsp_ channel in address
// order, rsp_last marking the final one; an empty table gives one result
// with status empty.
// Timing: one item is worked on at a time and req_stall is high meanwhile.
// An insert reads each entry above the new address and compares its start in
// the shared add/compare unit, shifting that entry up, then writes the new
// entry and answers; one that goes to the front skips the last compare, and a
// full table answers without a memory access. A dump reads and checks each
// entry after the first, then merges or lists it, whether merged or listed
// the single read port setting the pace; an empty dump gives one result.
// Results sit in an output register; while rsp_stall is high the sequencer
// waits at the next result and nothing is lost.
// Reset empties the table and the output register; no clearing pass runs.
//------------------------------------------------------------------------------
`default_nettype none

module free_block_table_coalesce
   import fbtc_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
)
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [15:0] req_block_addr,
   input  wire logic [15:0] req_block_size,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_entry_addr,
   output logic [23:0]      rsp_entry_size,
   output logic             rsp_last
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Table memory, one write and one registered read per cycle.
   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   entry_type wr_data;
   logic wr_en;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0] w_ff, w_in;
   logic mode_ff, mode_in;
   logic full_ff, full_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] size_ff, size_in;
   entry_type cur_ff, cur_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_kind_ff, rsp_kind_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_addr_ff, rsp_addr_in;
   logic [23:0] rsp_size_ff, rsp_size_in;
   logic rsp_last_ff, rsp_last_in;

   logic [23:0] alu_a, alu_b;
   logic [15:0] alu_c;
   alu_res_type alu_res;

   logic req_take;
   logic out_free;
   logic r_at_end;
   entry_type new_entry;

   fbtc_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .c   (alu_c),
      .res (alu_res)
   );

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign r_at_end  = ((CNT_W'(r_ff) + CNT_W'(1)) == count_ff);
   assign new_entry = '{start: addr_ff, length: {8'd0, size_ff}};

   // Insert reads the entry below the hole; dump reads the scan pointer.
   assign rd_addr = (mode_ff == MODE_DUMP) ? r_ff : (idx_ff - IDX_W'(1));

   // Sequencer: next state, memory control, unit operands and result loads.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      r_in          = r_ff;
      w_in          = w_ff;
      mode_in       = mode_ff;
      full_in       = full_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      cur_in        = cur_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = new_entry;
      alu_a         = {8'd0, addr_ff};
      alu_b         = 24'd0;
      alu_c         = rd_data_ff.start;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               mode_in = req_mode;
               addr_in = req_block_addr;
               size_in = req_block_size;
               full_in = 1'b0;
               r_in    = '0;
               if (req_mode == MODE_DUMP) begin
                  state_in = (count_ff == '0) ? S_EMPTY : S_DMP_RD0;
               end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  full_in  = 1'b1;
                  state_in = S_ACK;
               end else begin
                  idx_in   = count_ff[IDX_W-1:0];
                  state_in = (count_ff == '0) ? S_INS_PUT : S_INS_RD;
               end
            end
         end

         S_INS_RD: begin
            state_in = S_INS_CMP;
         end

         // Shift the entry up while its start lies above the new address.
         S_INS_CMP: begin
            if (alu_res.gt) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_data_ff;
               idx_in  = idx_ff - IDX_W'(1);
               state_in = (idx_ff == IDX_W'(1)) ? S_INS_PUT : S_INS_RD;
            end else begin
               state_in = S_INS_PUT;
            end
         end

         S_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = new_entry;
            count_in = count_ff + CNT_W'(1);
            state_in = S_ACK;
         end

         S_ACK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ACK;
               rsp_status_in = full_ff ? STATUS_FULL : STATUS_OK;
               rsp_addr_in   = addr_ff;
               rsp_size_in   = {8'd0, size_ff};
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_EMPTY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ENTRY;
               rsp_status_in = STATUS_EMPTY;
               rsp_addr_in   = 16'd0;
               rsp_size_in   = 24'd0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_DMP_RD0: begin
            state_in = S_DMP_LOAD;
         end

         // The first entry becomes the running entry.
         S_DMP_LOAD: begin
            cur_in   = rd_data_ff;
            r_in     = IDX_W'(1);
            w_in     = '0;
            state_in = (count_ff == CNT_W'(1)) ? S_DMP_FIN : S_DMP_RD;
         end

         S_DMP_RD: begin
            state_in = S_DMP_ADJ;
         end

         // Does the running entry end where the next one begins?
         S_DMP_ADJ: begin
            alu_a    = {8'd0, cur_ff.start};
            alu_b    = cur_ff.length;
            alu_c    = rd_data_ff.start;
            state_in = alu_res.eq ? S_DMP_SUM : S_DMP_EMIT;
         end

         // Absorb the next entry into the running one.
         S_DMP_SUM: begin
            alu_a         = cur_ff.length;
            alu_b         = rd_data_ff.length;
            alu_c         = 16'd0;
            cur_in.length = alu_res.sat;
            r_in          = r_ff + IDX_W'(1);
            state_in      = r_at_end ? S_DMP_FIN : S_DMP_RD;
         end

         // List and store the running entry, then move on to the next.
         S_DMP_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ENTRY;
               rsp_status_in = STATUS_OK;
               rsp_addr_in   = cur_ff.start;
               rsp_size_in   = cur_ff.length;
               rsp_last_in   = 1'b0;
               wr_en         = 1'b1;
               wr_addr       = w_ff;
               wr_data       = cur_ff;
               w_in          = w_ff + IDX_W'(1);
               cur_in        = rd_data_ff;
               r_in          = r_ff + IDX_W'(1);
               state_in      = r_at_end ? S_DMP_FIN : S_DMP_RD;
            end
         end

         S_DMP_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ENTRY;
               rsp_status_in = STATUS_OK;
               rsp_addr_in   = cur_ff.start;
               rsp_size_in   = cur_ff.length;
               rsp_last_in   = 1'b1;
               wr_en         = 1'b1;
               wr_addr       = w_ff;
               wr_data       = cur_ff;
               count_in      = CNT_W'(w_ff) + CNT_W'(1);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      r_ff          <= r_in;
      w_ff          <= w_in;
      mode_ff       <= mode_in;
      full_ff       <= full_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      cur_ff        <= cur_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_entry_addr = rsp_addr_ff;
   assign rsp_entry_size = rsp_size_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire
